// ----- hw/rtl/alir_pkg.sv -----
// alir_pkg: shared types, codes and sizes for the array list engine
// no dependencies; used by the interfaces, the cell and the top level
package alir_pkg;

   localparam int CAPACITY = 16;

   // width of the entry count, wide enough to hold CAPACITY itself
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // fixed field widths of the request and response words
   localparam int KIND_W  = 2;
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int CFLD_W  = 5;

   // common width for position / count compares
   localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

   // response status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_BEYOND  = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic                insert_en;
      logic                remove_en;
      logic [CNT_W-1:0]    pos;
      logic [VALUE_W-1:0]  value;
      logic [CNT_W-1:0]    count;
   } cmd_type;

   // count as seen on the response word, masked to its field width
   function automatic logic [CFLD_W-1:0] count_field(input logic [CNT_W-1:0] c);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(c);
      return w[CFLD_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/alir_ifs.sv -----
// alir_ifs: valid/ready channel interfaces for requests and responses
// depends on alir_pkg for field widths
interface alir_req_if;
   logic                          valid;
   logic                          ready;
   logic [alir_pkg::KIND_W-1:0]   kind;
   logic [alir_pkg::POS_W-1:0]    position;
   logic signed [alir_pkg::VALUE_W-1:0] value;

   modport source (output valid, output kind, output position, output value, input ready);
   modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface alir_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [alir_pkg::STAT_W-1:0]   status;
   logic [alir_pkg::CFLD_W-1:0]   count;

   modport source (output valid, output status, output count, input ready);
   modport sink   (input valid, input status, input count, output ready);
endinterface

// ----- hw/rtl/alir_cell.sv -----
// alir_cell: one slot of the list, compares against the command value and
// shifts with its neighbors; depends on alir_pkg
module alir_cell (
   input  logic                          clock,
   input  alir_pkg::cmd_type             cmd,
   input  logic [alir_pkg::CNT_W-1:0]    cell_idx,
   input  logic [alir_pkg::VALUE_W-1:0]  left_entry,
   input  logic [alir_pkg::VALUE_W-1:0]  right_entry,
   input  logic                          hit_in,
   output logic [alir_pkg::VALUE_W-1:0]  entry,
   output logic                          hit_out
);

   logic [alir_pkg::VALUE_W-1:0] entry_ff;
   logic [alir_pkg::VALUE_W-1:0] entry_in;
   logic                         occupied;
   logic                         match;

   assign occupied = cell_idx < cmd.count;
   assign match    = occupied && (entry_ff == cmd.value);
   assign hit_out  = hit_in | match;
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert_en) begin
         if (cell_idx == cmd.pos) begin
            entry_in = cmd.value;
         end else if (cell_idx > cmd.pos) begin
            entry_in = left_entry;
         end
      end else if (cmd.remove_en && hit_out) begin
         // at and after the first match, pull from the right
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- hw/rtl/array_list_insert_remove.sv -----
// array_list_insert_remove: ordered list engine built as a chain of cells
// depends on alir_pkg, alir_ifs (alir_req_if, alir_rsp_if) and alir_cell
//
//   channel   dir   word                          handshake
//   req_bus   in    kind, position, value         valid / ready
//   rsp_bus   out   status, count                 valid / ready
//
// one request per cycle while the response is taken: every cell compares and shifts in the accept cycle,
// the first-match flag ripples through the cell chain
// the response appears in the cycle after accept, from an output register
// reset clears the entry count and the response valid; entry contents are
// not cleared, slots at or above the count are never read
// a stalled response holds req ready low only if the response is not taken
module array_list_insert_remove (
   input  logic            clock,
   input  logic            reset,
   alir_req_if.sink        req_bus,
   alir_rsp_if.source      rsp_bus
);

   localparam int CAP = alir_pkg::CAPACITY;
   localparam int CW  = alir_pkg::CNT_W;
   localparam int WW  = alir_pkg::WIDE_W;

   // entry count and response register
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [alir_pkg::STAT_W-1:0]  rsp_status_ff;
   logic [alir_pkg::STAT_W-1:0]  rsp_status_in;
   logic [alir_pkg::CFLD_W-1:0]  rsp_count_ff;
   logic [alir_pkg::CFLD_W-1:0]  rsp_count_in;

   logic                         accept;
   logic                         found;
   logic                         beyond;
   logic                         full;
   logic                         ins_ok;
   logic                         rem_ok;
   logic [WW-1:0]                ins_pos;
   logic [alir_pkg::STAT_W-1:0]  status;
   alir_pkg::cmd_type            cmd;

   // cell chain wiring
   logic [alir_pkg::VALUE_W-1:0] entry_q [CAP];
   logic [CAP:0]                 hit_chain;

   // accept while the response register is empty or being drained
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // append is an insert at the current count
   assign ins_pos = (req_bus.kind == alir_pkg::KIND_APPEND) ? WW'(count_ff)
                                                            : WW'(req_bus.position);
   assign beyond  = ins_pos > WW'(count_ff);
   assign full    = WW'(count_ff) >= WW'(CAP);
   assign found   = hit_chain[CAP];

   always_comb begin
      ins_ok = 1'b0;
      rem_ok = 1'b0;
      status = alir_pkg::ST_OK;
      unique case (req_bus.kind) inside
         alir_pkg::KIND_INSERT, alir_pkg::KIND_APPEND: begin
            // position test comes before the full test
            if (beyond) begin
               status = alir_pkg::ST_BEYOND;
            end else if (full) begin
               status = alir_pkg::ST_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         alir_pkg::KIND_REMOVE: begin
            if (found) begin
               rem_ok = 1'b1;
            end else begin
               status = alir_pkg::ST_MISSING;
            end
         end
         default: begin
            status = found ? alir_pkg::ST_OK : alir_pkg::ST_MISSING;
         end
      endcase
   end

   // command broadcast to all cells, writes gated by accept
   always_comb begin
      cmd.insert_en = accept && ins_ok;
      cmd.remove_en = accept && rem_ok;
      cmd.pos       = CW'(ins_pos);
      cmd.value     = req_bus.value;
      cmd.count     = count_ff;
   end

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [alir_pkg::VALUE_W-1:0] left_w;
      logic [alir_pkg::VALUE_W-1:0] right_w;

      // ends of the chain feed back values that are never selected (left end) or never read (right end)
      if (i == 0) begin : g_first
         assign left_w = req_bus.value;
      end else begin : g_mid_l
         assign left_w = entry_q[i-1];
      end
      if (i == CAP - 1) begin : g_last
         assign right_w = entry_q[i];
      end else begin : g_mid_r
         assign right_w = entry_q[i+1];
      end

      alir_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_idx    (CW'(i)),
         .left_entry  (left_w),
         .right_entry (right_w),
         .hit_in      (hit_chain[i]),
         .entry       (entry_q[i]),
         .hit_out     (hit_chain[i+1])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         if (ins_ok) begin
            count_in = count_ff + CW'(1);
         end else if (rem_ok) begin
            count_in = count_ff - CW'(1);
         end
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_count_in  = alir_pkg::count_field(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.count  = rsp_count_ff;

`ifndef SYNTHESIS
   // count never exceeds the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      WW'(count_ff) <= WW'(CAP))
      else $error("entry count above capacity");

   // a successful insert grows the list by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && ins_ok) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the count");

   // failed or read-only requests leave the count alone
   a_no_change: assert property (@(posedge clock) disable iff (reset)
      (accept && !ins_ok && !rem_ok) |=> $stable(count_ff))
      else $error("count changed on a request without effect");

   // a full status is reported only with the store at capacity
   a_full_at_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == alir_pkg::ST_FULL) |-> (WW'(count_ff) == WW'(CAP)))
      else $error("full status below capacity");

   // a remove can only succeed on a non-empty list
   a_remove_nonempty: assert property (@(posedge clock) disable iff (reset)
      (accept && rem_ok) |-> (count_ff != '0))
      else $error("remove hit on an empty list");
`endif

endmodule
